/* rtl/core/rsd_pkg.sv */
// Shared types and constants for the run-length sprite row decoder.
// No dependencies; used by rsd_step, the top level and the testbench.
package rsd_pkg;

  localparam logic [15:0] OP_FILL = 16'h00C0;
  localparam logic [15:0] OP_LIT1 = 16'h00C1;
  localparam logic [15:0] OP_LIT2 = 16'h00C2;
  localparam logic [15:0] OP_LIT3 = 16'h00C3;

  localparam int unsigned HEIGHT_W = 11;
  localparam int unsigned ROW_W    = 10;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned CMP_W    = 13;

  typedef enum logic [2:0] {
    PH_LEN,
    PH_OPCODE,
    PH_FILL_COUNT,
    PH_LIT_COUNT,
    PH_LITERAL,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    KIND_FILL    = 2'd0,
    KIND_PIXEL   = 2'd1,
    KIND_ROW_END = 2'd2,
    KIND_BAD     = 2'd3
  } kind_e;

  typedef struct packed {
    phase_e              phase;
    logic [WORD_W-1:0]   body_left;
    logic [WORD_W-1:0]   run_left;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
  } state_t;

  typedef struct packed {
    kind_e         kind;
    logic [9:0]    row;
    logic [9:0]    column;
    logic [10:0]   run_length;
    logic [15:0]   pixel_value;
    logic          last_of_image;
  } result_t;

endpackage

/* rtl/core/rsd_in_if.sv */
// Valid/ready channel carrying one compressed stream word per beat.
// Depends on nothing.
interface rsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] src_word;

  modport source (output valid, output src_word, input ready);
  modport sink (input valid, input src_word, output ready);
endinterface

/* rtl/core/rsd_out_if.sv */
// Valid/ready channel carrying one decoded result per beat.
// Depends on nothing.
interface rsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  row;
  logic [9:0]  column;
  logic [10:0] run_length;
  logic [15:0] pixel_value;
  logic        last_of_image;

  modport source (
    output valid, output kind, output row, output column,
    output run_length, output pixel_value, output last_of_image,
    input ready
  );
  modport sink (
    input valid, input kind, input row, input column,
    input run_length, input pixel_value, input last_of_image,
    output ready
  );
endinterface

/* rtl/core/rsd_step.sv */
// Decode logic for one stream word: next state and optional result.
// Depends on rsd_pkg.
module rsd_step #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  rsd_pkg::state_t       state_i,
  input  logic [15:0]           word_i,
  input  logic [10:0]           height_i,
  output rsd_pkg::state_t       state_o,
  output logic                  emit_o,
  output rsd_pkg::result_t      result_o
);
  import rsd_pkg::*;

  localparam logic [CMP_W-1:0]  MaxH = CMP_W'(MAX_HEIGHT);
  localparam logic [WORD_W:0]   MaxW = (WORD_W + 1)'(MAX_WIDTH);

  logic [CMP_W-1:0]  eff_h;
  logic [CMP_W-1:0]  row_inc;
  logic              last_row;
  logic [WORD_W:0]   col_sum;
  logic [WORD_W-1:0] left;
  logic              is_op;

  always_comb begin
    eff_h    = ({2'b00, height_i} < MaxH) ? {2'b00, height_i} : MaxH;
    row_inc  = CMP_W'(state_i.row) + CMP_W'(1);
    last_row = (row_inc >= eff_h);
    col_sum  = (WORD_W + 1)'(state_i.column) + (WORD_W + 1)'(word_i);
    left     = state_i.body_left;
    is_op    = word_i inside {OP_FILL, OP_LIT1, OP_LIT2, OP_LIT3};
  end

  always_comb begin
    state_o = state_i;
    emit_o  = 1'b0;
    result_o.kind          = KIND_BAD;
    result_o.row           = state_i.row;
    result_o.column        = state_i.column[9:0];
    result_o.run_length    = '0;
    result_o.pixel_value   = word_i;
    result_o.last_of_image = 1'b0;

    if (eff_h == '0) begin
      emit_o = 1'b1;
    end else if (state_i.phase == PH_LEN && word_i != '0) begin
      state_o.body_left = word_i;
      state_o.column    = '0;
      state_o.phase     = PH_OPCODE;
    end else if (state_i.phase == PH_LEN || left <= WORD_W'(1)) begin
      // row end: zero length word or padding word
      emit_o                 = 1'b1;
      result_o.kind          = KIND_ROW_END;
      result_o.column        = '0;
      result_o.pixel_value   = '0;
      result_o.last_of_image = last_row;
      state_o.row       = last_row ? '0 : row_inc[ROW_W-1:0];
      state_o.column    = '0;
      state_o.run_left  = '0;
      state_o.body_left = '0;
      state_o.phase     = PH_LEN;
    end else begin
      state_o.body_left = left - WORD_W'(1);
      case (state_i.phase)
        PH_OPCODE: begin
          if (!is_op) begin
            emit_o = 1'b1;
          end else if (left <= WORD_W'(2)) begin
            emit_o        = 1'b1;
            state_o.phase = PH_SKIP;
          end else begin
            state_o.phase = (word_i == OP_FILL) ? PH_FILL_COUNT : PH_LIT_COUNT;
          end
        end
        PH_FILL_COUNT: begin
          if (col_sum > MaxW) begin
            emit_o        = 1'b1;
            state_o.phase = PH_SKIP;
          end else begin
            state_o.phase = PH_OPCODE;
            if (word_i != '0) begin
              emit_o               = 1'b1;
              result_o.kind        = KIND_FILL;
              result_o.run_length  = word_i[10:0];
              result_o.pixel_value = '0;
              state_o.column       = col_sum[COL_W-1:0];
            end
          end
        end
        PH_LIT_COUNT: begin
          if (word_i > (left - WORD_W'(2)) || col_sum > MaxW) begin
            emit_o        = 1'b1;
            state_o.phase = PH_SKIP;
          end else if (word_i == '0) begin
            state_o.phase = PH_OPCODE;
          end else begin
            state_o.run_left = word_i;
            state_o.phase    = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          emit_o              = 1'b1;
          result_o.kind       = KIND_PIXEL;
          result_o.run_length = 11'd1;
          state_o.column      = state_i.column + COL_W'(1);
          state_o.run_left    = state_i.run_left - WORD_W'(1);
          if (state_i.run_left == WORD_W'(1)) begin
            state_o.phase = PH_OPCODE;
          end
        end
        default: begin
          state_o.phase = PH_SKIP;
        end
      endcase
    end
  end

endmodule

/* rtl/core/rle_sprite_row_decoder.sv */
// Run-length sprite row decoder, top level. Depends on rsd_pkg, rsd_in_if,
// rsd_out_if and rsd_step.
// Each result is registered. Throughput: one word per cycle while the result
// register is empty or its result is taken; the result register takes a new
// result in the cycle its current one is taken. Async active-low reset clears
// the decode state, the height register and the result valid.
module rle_sprite_row_decoder #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  rsd_in_if.sink      src_i,
  rsd_out_if.source   res_o
);
  import rsd_pkg::*;

  state_t             state_q, state_d;
  logic [HEIGHT_W-1:0] height_q;
  result_t            res_q, res_d;
  logic               valid_q;
  logic               emit;
  logic               accept;

  rsd_step #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_step (
    .state_i (state_q),
    .word_i  (src_i.src_word),
    .height_i(height_q),
    .state_o (state_d),
    .emit_o  (emit),
    .result_o(res_d)
  );

  assign src_i.ready = !valid_q || res_o.ready;
  assign accept      = src_i.valid && src_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '{phase: PH_LEN, default: '0};
      height_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        height_q <= cfg_wdata_i;
      end
      if (accept) begin
        state_q <= state_d;
        valid_q <= emit;
      end else if (res_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.kind          = res_q.kind;
  assign res_o.row           = res_q.row;
  assign res_o.column        = res_q.column;
  assign res_o.run_length    = res_q.run_length;
  assign res_o.pixel_value   = res_q.pixel_value;
  assign res_o.last_of_image = res_q.last_of_image;

endmodule

/* verif/tb_rle_sprite_row_decoder.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rle_sprite_row_decoder: directed rows, height changes,
// a full-height sprite and random sprite streams, checked against an in-bench decoder.
// Depends on rsd_pkg, rsd_in_if, rsd_out_if and the decoder RTL.
module tb_rle_sprite_row_decoder;
  import rsd_pkg::*;

  localparam int unsigned MAX_W = 1024;
  localparam int unsigned MAX_H = 1024;
  localparam int unsigned CYCLE_LIMIT = 300000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [10:0] cfg_wdata_i;

  rsd_in_if  src ();
  rsd_out_if res ();

  rle_sprite_row_decoder #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .src_i       (src),
    .res_o       (res)
  );

  // decoder state as predicted
  phase_e      dec_phase;
  logic [15:0] dec_body_left;
  logic [15:0] dec_run_left;
  logic [10:0] dec_column;
  logic [9:0]  dec_row;
  logic [10:0] dec_height;

  result_t     pending_results[$];
  result_t     want;
  logic [15:0] row_body[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned words_sent;
  int unsigned results_checked;
  int unsigned height_writes;
  int unsigned fails;
  int unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $realtime, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        fails++;
        $display("%0t: unexpected result kind %0d row %0d col %0d len %0d pix %h last %0d",
                 $realtime, res.kind, res.row, res.column, res.run_length,
                 res.pixel_value, res.last_of_image);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (res.kind !== want.kind || res.row !== want.row || res.column !== want.column ||
            res.run_length !== want.run_length || res.pixel_value !== want.pixel_value ||
            res.last_of_image !== want.last_of_image) begin
          fails++;
          $display("%0t: expected kind %0d row %0d col %0d len %0d pix %h last %0d, %s",
                   $realtime, want.kind, want.row, want.column, want.run_length,
                   want.pixel_value, want.last_of_image,
                   $sformatf("got kind %0d row %0d col %0d len %0d pix %h last %0d",
                             res.kind, res.row, res.column, res.run_length,
                             res.pixel_value, res.last_of_image));
        end
      end
    end
  end

  // Advances the predicted state by one stream word; returns 1 when a result is due.
  function automatic bit decode_word(input logic [15:0] w, output result_t r);
    int unsigned h_eff;
    int unsigned left;
    bit          last;
    h_eff = (dec_height < MAX_H) ? dec_height : MAX_H;
    r = '0;
    r.kind = KIND_BAD;
    r.row = dec_row;
    r.column = dec_column[9:0];
    r.pixel_value = w;
    if (h_eff == 0) return 1'b1;
    left = 0;
    if (dec_phase == PH_LEN) begin
      if (w != 16'd0) begin
        dec_body_left = w;
        dec_column = '0;
        dec_phase = PH_OPCODE;
        return 1'b0;
      end
    end else begin
      left = dec_body_left;
      dec_body_left = dec_body_left - 16'd1;
    end
    if (dec_phase == PH_LEN || left <= 1) begin
      last = (int'(dec_row) + 1 >= h_eff);
      r.kind = KIND_ROW_END;
      r.column = '0;
      r.pixel_value = '0;
      r.last_of_image = last;
      dec_row = last ? 10'd0 : dec_row + 10'd1;
      dec_column = '0;
      dec_run_left = '0;
      dec_body_left = '0;
      dec_phase = PH_LEN;
      return 1'b1;
    end
    case (dec_phase)
      PH_OPCODE: begin
        if (w != OP_FILL && w != OP_LIT1 && w != OP_LIT2 && w != OP_LIT3) return 1'b1;
        if (left <= 2) begin
          dec_phase = PH_SKIP;
          return 1'b1;
        end
        dec_phase = (w == OP_FILL) ? PH_FILL_COUNT : PH_LIT_COUNT;
        return 1'b0;
      end
      PH_FILL_COUNT: begin
        if (int'(dec_column) + int'(w) > MAX_W) begin
          dec_phase = PH_SKIP;
          return 1'b1;
        end
        dec_phase = PH_OPCODE;
        if (w == 16'd0) return 1'b0;
        r.kind = KIND_FILL;
        r.run_length = w[10:0];
        r.pixel_value = '0;
        dec_column = dec_column + w[10:0];
        return 1'b1;
      end
      PH_LIT_COUNT: begin
        if (int'(w) > int'(left) - 2 || int'(dec_column) + int'(w) > MAX_W) begin
          dec_phase = PH_SKIP;
          return 1'b1;
        end
        if (w == 16'd0) begin
          dec_phase = PH_OPCODE;
          return 1'b0;
        end
        dec_run_left = w;
        dec_phase = PH_LITERAL;
        return 1'b0;
      end
      PH_LITERAL: begin
        r.kind = KIND_PIXEL;
        r.run_length = 11'd1;
        dec_column = dec_column + 11'd1;
        dec_run_left = dec_run_left - 16'd1;
        if (dec_run_left == 16'd0) dec_phase = PH_OPCODE;
        return 1'b1;
      end
      default: begin
        dec_phase = PH_SKIP;
        return 1'b0;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_word(input logic [15:0] w);
    result_t r;
    while ($urandom_range(99, 0) < snd_idle_pct) begin
      src.valid <= 1'b0;
      @(negedge clk_i);
    end
    src.valid <= 1'b1;
    src.src_word <= w;
    do @(posedge clk_i); while (!src.ready);
    if (decode_word(w, r)) pending_results.push_back(r);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_row();
    send_word(16'(row_body.size()));
    foreach (row_body[i]) send_word(row_body[i]);
  endtask

  task automatic wait_idle();
    src.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_height(input logic [10:0] h);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= h;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    dec_height = h;
    height_writes++;
  endtask

  // Well-formed row body with random runs; a flawed row carries one defect near its end.
  task automatic build_row(input bit flawed);
    int unsigned col;
    int unsigned room;
    int unsigned n;
    int unsigned segs;
    logic [15:0] op;
    row_body.delete();
    col = 0;
    segs = $urandom_range(4, 0);
    repeat (segs) begin
      room = MAX_W - col;
      if ($urandom_range(1, 0) == 1) begin
        if ($urandom_range(15, 0) == 0) n = $urandom_range(room, 0);
        else n = $urandom_range((room < 12) ? room : 12, 0);
        row_body.push_back(OP_FILL);
        row_body.push_back(16'(n));
      end else begin
        n = $urandom_range((room < 6) ? room : 6, 0);
        case ($urandom_range(2, 0))
          0: op = OP_LIT1;
          1: op = OP_LIT2;
          default: op = OP_LIT3;
        endcase
        row_body.push_back(op);
        row_body.push_back(16'(n));
        repeat (n) row_body.push_back(16'($urandom_range(16'hFFFF, 0)));
      end
      col += n;
    end
    if (flawed) begin
      case ($urandom_range(3, 0))
        0: row_body.push_back(16'($urandom_range(16'hFFFF, 0)));
        1: begin
          n = $urandom_range(3, 0);
          row_body.push_back(OP_LIT3);
          row_body.push_back(16'(n + 1 + $urandom_range(3, 0)));
          repeat (n) row_body.push_back(16'($urandom_range(16'hFFFF, 0)));
        end
        2: begin
          room = MAX_W - col;
          if (room >= 4) begin
            n = room - $urandom_range(3, 0);
            row_body.push_back(OP_FILL);
            row_body.push_back(16'(n));
            col += n;
          end
          n = MAX_W - col + 1;
          if ($urandom_range(1, 0) == 1) begin
            row_body.push_back(OP_FILL);
            row_body.push_back(16'(n + $urandom_range(40, 0)));
          end else begin
            row_body.push_back(OP_LIT2);
            row_body.push_back(16'(n));
            repeat (n) row_body.push_back(16'($urandom_range(16'hFFFF, 0)));
          end
        end
        default: row_body.push_back(16'($urandom_range(OP_LIT3, OP_FILL)));
      endcase
    end
    row_body.push_back(16'($urandom_range(16'hFFFF, 0)));
  endtask

  task automatic send_noise_row();
    int unsigned n;
    n = $urandom_range(12, 0);
    send_word(16'(n));
    repeat (n) begin
      case ($urandom_range(2, 0))
        0: send_word(16'($urandom_range(16'hC4, 16'hBF)));
        1: send_word(16'($urandom_range(8, 0)));
        default: send_word(16'($urandom_range(16'hFFFF, 0)));
      endcase
    end
  endtask

  task automatic send_sprite(input int unsigned rows);
    int unsigned pick;
    repeat (rows) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) send_word(16'd0);
      else if (pick < 78) begin
        build_row(1'b0);
        send_row();
      end else if (pick < 92) begin
        build_row(1'b1);
        send_row();
      end else send_noise_row();
    end
  endtask

  task automatic test_directed();
    write_height(11'd0);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(OP_FILL);
    write_height(11'd1);
    send_word(16'd0);
    write_height(11'd3);
    // zero counts, fill, literals, unknown opcode, opcode against the padding word
    row_body = '{OP_FILL, 16'd0, OP_FILL, 16'd5, OP_LIT1, 16'd2, 16'hFFFF, 16'h0000,
                 OP_LIT2, 16'd0, 16'h1234, OP_LIT3, 16'h5A5A};
    send_row();
    // literal run reaching into the padding word
    row_body = '{OP_LIT1, 16'd3, 16'hAAAA, 16'h5555, 16'h0F0F};
    send_row();
    // full-width fill, then a column overflow
    row_body = '{OP_FILL, 16'h0400, OP_FILL, 16'd1, 16'hFFFF};
    send_row();
  endtask

  task automatic test_height_change();
    write_height(11'd2047);
    repeat (3) send_word(16'd0);
    write_height(11'd2);
    send_word(16'd0);
  endtask

  task automatic test_full_height();
    int unsigned rows;
    write_height(11'd2047);
    rows = MAX_H - dec_row;
    repeat (rows) begin
      if ($urandom_range(63, 0) == 0) begin
        build_row(1'b0);
        send_row();
      end else send_word(16'd0);
    end
  endtask

  task automatic test_random_sprites(input int unsigned n_words, input int unsigned snd_pct,
                                     input int unsigned rcv_pct);
    int unsigned start;
    int unsigned hsel;
    int unsigned h;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    start = words_sent;
    while (words_sent - start < n_words) begin
      hsel = $urandom_range(19, 0);
      if (hsel == 0) h = 0;
      else if (hsel == 1) h = 2047;
      else if (hsel == 2) h = 1024;
      else h = $urandom_range(6, 1);
      write_height(11'(h));
      if (h == 0) repeat ($urandom_range(4, 1)) send_word(16'($urandom_range(16'hFFFF, 0)));
      else if (h > 6) send_sprite($urandom_range(8, 1));
      else if ($urandom_range(3, 0) == 0) send_sprite($urandom_range(h, 1));
      else send_sprite(h);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    src.valid = 1'b0;
    src.src_word = '0;
    res.ready = 1'b0;
    snd_idle_pct = 11;
    rcv_idle_pct = 73;
    dec_phase = PH_LEN;
    dec_body_left = '0;
    dec_run_left = '0;
    dec_column = '0;
    dec_row = '0;
    dec_height = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_height_change();
    test_random_sprites(120, 11, 73);
    test_random_sprites(120, 73, 11);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_full_height();
    test_random_sprites(80, 0, 0);

    wait_idle();
    $display("Decoded %0d stream words into %0d checked results over %0d height writes,",
             words_sent, results_checked, height_writes);
    $display("with random stalls on either side and a full-height sprite streamed back to back.");
    if (fails == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
